// ===== design/geffe_keystream_byte_xor_defines.svh =====
// Assertion macros for the Geffe keystream XOR block.
`ifndef GEFFE_KEYSTREAM_BYTE_XOR_DEFINES_SVH
`define GEFFE_KEYSTREAM_BYTE_XOR_DEFINES_SVH

// Same-cycle implication, disabled while in reset.
`define GKS_ASSERT_NOW(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("gks assertion failed");

// Next-cycle implication, disabled while in reset.
`define GKS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("gks assertion failed");

`endif

// ===== design/gks_pkg.sv =====
// Package: types and LFSR step functions for the Geffe keystream XOR block.
package gks_pkg;

  localparam int unsigned DataW   = 8;
  localparam int unsigned KeyW    = 32;
  localparam int unsigned LongW   = 16;
  localparam int unsigned ShortW  = 7;
  localparam int unsigned MidW    = 9;
  localparam logic [KeyW-1:0] KeyReset = 32'h0000_0001;

  typedef struct packed {
    logic [LongW-1:0]  long_lfsr;
    logic [ShortW-1:0] short_lfsr;
    logic [MidW-1:0]   mid_lfsr;
  } lfsr_state_t;

  typedef struct packed {
    logic [DataW-1:0] ks;
    lfsr_state_t      next;
  } ks_result_t;

  typedef struct packed {
    logic advance;
    logic restart;
  } keygen_ctrl_t;

  function automatic lfsr_state_t seeds_from_key(input logic [KeyW-1:0] key);
    lfsr_state_t s;
    s.long_lfsr  = key[15:0];
    s.short_lfsr = key[23:17];
    s.mid_lfsr   = {2'b00, key[31:25]};
    return s;
  endfunction

  // Eight steps of all three registers; first keystream bit lands in the MSB.
  function automatic ks_result_t keystream_byte(input lfsr_state_t start);
    ks_result_t r;
    lfsr_state_t s;
    logic fb_l;
    logic fb_s;
    logic fb_m;
    s = start;
    r.ks = '0;
    for (int i = 0; i < DataW; i++) begin
      fb_l = s.long_lfsr[12] ^ s.long_lfsr[3] ^ s.long_lfsr[1] ^ s.long_lfsr[0];
      fb_s = s.short_lfsr[1] ^ s.short_lfsr[0];
      fb_m = s.mid_lfsr[4] ^ s.mid_lfsr[0];
      s.long_lfsr  = {fb_l, s.long_lfsr[LongW-1:1]};
      s.short_lfsr = {fb_s, s.short_lfsr[ShortW-1:1]};
      s.mid_lfsr   = {fb_m, s.mid_lfsr[MidW-1:1]};
      r.ks[DataW-1-i] = s.short_lfsr[0] ? s.long_lfsr[0] : s.mid_lfsr[0];
    end
    r.next = s;
    return r;
  endfunction

endpackage

// ===== design/gks_keygen.sv =====
// Keystream generator: LFSR state register and the one-byte keystream logic.
module gks_keygen (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  gks_pkg::keygen_ctrl_t       ctrl_i,
  input  logic [gks_pkg::KeyW-1:0]    seed_key_i,
  output logic [gks_pkg::DataW-1:0]   ks_o
);

  gks_pkg::lfsr_state_t state_q, state_d;
  gks_pkg::lfsr_state_t start;
  gks_pkg::ks_result_t  res;

  always_comb begin
    start   = ctrl_i.restart ? gks_pkg::seeds_from_key(seed_key_i) : state_q;
    res     = gks_pkg::keystream_byte(start);
    state_d = ctrl_i.advance ? res.next : state_q;
  end

  assign ks_o = res.ks;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= gks_pkg::seeds_from_key(gks_pkg::KeyReset);
    end else begin
      state_q <= state_d;
    end
  end

endmodule

// ===== design/geffe_keystream_byte_xor.sv =====
// Geffe keystream XOR block: takes one byte per item and returns it XORed with
// eight keystream bits. An item can be accepted every clock cycle while the
// output side keeps up; an accepted item is held in the input register, then
// moves into the result register, which drives the output, with all eight LFSR
// steps done combinationally between them. Ready falls only when both registers
// are full and the output side stalls. A seed_key write takes effect at the next
// restart item.
module geffe_keystream_byte_xor (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       cfg_we_i,
  input  logic [gks_pkg::KeyW-1:0]   cfg_wdata_i,
  input  logic                       in_valid_i,
  output logic                       in_ready_o,
  input  logic [gks_pkg::DataW-1:0]  data_byte_i,
  input  logic                       restart_i,
  output logic                       out_valid_o,
  input  logic                       out_ready_i,
  output logic [gks_pkg::DataW-1:0]  out_byte_o
);

  logic [gks_pkg::KeyW-1:0]  seed_key_q;
  logic                      in_valid_q;
  logic [gks_pkg::DataW-1:0] in_data_q;
  logic                      in_restart_q;
  logic                      out_valid_q;
  logic [gks_pkg::DataW-1:0] out_byte_q;
  logic [gks_pkg::DataW-1:0] ks;
  logic                      out_free;
  logic                      in_free;
  logic                      move;
  gks_pkg::keygen_ctrl_t     kg_ctrl;

  assign out_free   = !out_valid_q || out_ready_i;
  assign move       = in_valid_q && out_free;
  assign in_free    = !in_valid_q || out_free;
  assign in_ready_o = in_free;

  assign kg_ctrl.advance = move;
  assign kg_ctrl.restart = in_restart_q;

  gks_keygen u_keygen (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .ctrl_i     (kg_ctrl),
    .seed_key_i (seed_key_q),
    .ks_o       (ks)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seed_key_q  <= gks_pkg::KeyReset;
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        seed_key_q <= cfg_wdata_i;
      end
      if (in_free) begin
        in_valid_q <= in_valid_i;
      end
      if (out_free) begin
        out_valid_q <= in_valid_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_free && in_valid_i) begin
      in_data_q    <= data_byte_i;
      in_restart_q <= restart_i;
    end
    if (move) begin
      out_byte_q <= in_data_q ^ ks;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_byte_o  = out_byte_q;

endmodule

// ===== design/gks_checker.sv =====
// Port-level checker for the Geffe keystream XOR block, bound to the top level.
`include "geffe_keystream_byte_xor_defines.svh"

module gks_checker (
  input logic                       clk_i,
  input logic                       rst_ni,
  input logic                       in_valid_i,
  input logic                       in_ready_o,
  input logic                       out_valid_o,
  input logic                       out_ready_i,
  input logic [gks_pkg::DataW-1:0]  out_byte_o
);

  `GKS_ASSERT_NEXT(a_out_valid_hold, clk_i, rst_ni, out_valid_o && !out_ready_i, out_valid_o)
  `GKS_ASSERT_NEXT(a_out_byte_hold, clk_i, rst_ni, out_valid_o && !out_ready_i, $stable(out_byte_o))
  `GKS_ASSERT_NOW(a_ready_when_out_empty, clk_i, rst_ni, !out_valid_o, in_ready_o)
  `GKS_ASSERT_NEXT(a_item_reaches_output, clk_i, rst_ni, in_valid_i && in_ready_o, ##1 out_valid_o)

endmodule

bind geffe_keystream_byte_xor gks_checker u_gks_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_ready_o  (in_ready_o),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .out_byte_o  (out_byte_o)
);

// ===== test/testbench.sv =====
`timescale 1ns / 100ps
// Testbench for geffe_keystream_byte_xor: random traffic checked against an internal keystream predictor.
module testbench;

  localparam int unsigned QuietLimit = 4000;

  typedef struct {
    logic [gks_pkg::DataW-1:0] data;
    logic                      restart;
  } cipher_item_t;

  typedef enum int {
    ReadyAlways,
    ReadyCoin,
    ReadyPattern,
    ReadySparse
  } ready_mode_e;

  logic                        clk_i = 1'b0;
  logic                        rst_ni = 1'b0;
  logic                        cfg_we_i = 1'b0;
  logic [gks_pkg::KeyW-1:0]    cfg_wdata_i = '0;
  logic                        in_valid_i = 1'b0;
  logic                        in_ready_o;
  logic [gks_pkg::DataW-1:0]   data_byte_i = '0;
  logic                        restart_i = 1'b0;
  logic                        out_valid_o;
  logic                        out_ready_i = 1'b0;
  logic [gks_pkg::DataW-1:0]   out_byte_o;

  cipher_item_t                pending_items[$];
  logic [gks_pkg::DataW-1:0]   expected_bytes[$];

  logic [gks_pkg::KeyW-1:0]    key_shadow;
  logic [gks_pkg::LongW-1:0]   long_reg;
  logic [gks_pkg::ShortW-1:0]  short_reg;
  logic [gks_pkg::MidW-1:0]    mid_reg;

  int unsigned                 burst_left = 1;
  int unsigned                 gap_left = 0;
  cipher_item_t                next_item;
  ready_mode_e                 ready_mode = ReadyAlways;
  int unsigned                 mode_left = 0;
  int unsigned                 cycle_count = 0;
  int unsigned                 quiet_cycles = 0;
  int unsigned                 errors = 0;
  logic [gks_pkg::DataW-1:0]   want;

  geffe_keystream_byte_xor DUT (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .data_byte_i (data_byte_i),
    .restart_i   (restart_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_byte_o  (out_byte_o)
  );

  always #5 clk_i = ~clk_i;

  function automatic void reload_seeds();
    long_reg  = key_shadow[15:0];
    short_reg = key_shadow[23:17];
    mid_reg   = {2'b00, key_shadow[31:25]};
  endfunction

  // Steps all three registers eight times; first keystream bit ends up in the MSB.
  function automatic logic [gks_pkg::DataW-1:0] cipher_byte(
    input logic [gks_pkg::DataW-1:0] data,
    input logic                      restart
  );
    logic [gks_pkg::DataW-1:0] ks;
    ks = '0;
    if (restart) reload_seeds();
    for (int i = 0; i < gks_pkg::DataW; i++) begin
      long_reg  = {long_reg[12] ^ long_reg[3] ^ long_reg[1] ^ long_reg[0], long_reg[15:1]};
      short_reg = {short_reg[1] ^ short_reg[0], short_reg[6:1]};
      mid_reg   = {mid_reg[4] ^ mid_reg[0], mid_reg[8:1]};
      ks = {ks[gks_pkg::DataW-2:0], short_reg[0] ? long_reg[0] : mid_reg[0]};
    end
    return data ^ ks;
  endfunction

  task automatic push_item(input logic [gks_pkg::DataW-1:0] data, input logic restart);
    cipher_item_t it;
    it.data    = data;
    it.restart = restart;
    pending_items.push_back(it);
  endtask

  task automatic wait_drained();
    do @(negedge clk_i);
    while (pending_items.size() != 0 || in_valid_i || expected_bytes.size() != 0);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_key(input logic [gks_pkg::KeyW-1:0] key);
    @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= key;
    key_shadow   = key;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
  endtask

  // Sender: bursts of random length separated by random gaps.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
    end else begin
      if (in_valid_i && in_ready_o) begin
        expected_bytes.push_back(cipher_byte(data_byte_i, restart_i));
      end
      if (!in_valid_i || in_ready_o) begin
        if (gap_left > 0) begin
          gap_left--;
          in_valid_i <= 1'b0;
        end else if (pending_items.size() > 0) begin
          next_item = pending_items.pop_front();
          in_valid_i  <= 1'b1;
          data_byte_i <= next_item.data;
          restart_i   <= next_item.restart;
          if (burst_left <= 1) begin
            burst_left = $urandom_range(1, 32);
            gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
          end else begin
            burst_left--;
          end
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // Receiver: checks each item and stalls according to a randomly chosen ready mode that is re-chosen over time.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
    end else begin
      cycle_count++;
      if (out_valid_o && out_ready_i) begin
        if (expected_bytes.size() == 0) begin
          $display("%0t: out_byte_o expected none got %02h", $time, out_byte_o);
          errors++;
        end else begin
          want = expected_bytes.pop_front();
          if (want !== out_byte_o) begin
            $display("%0t: out_byte_o expected %02h got %02h", $time, want, out_byte_o);
            errors++;
          end
        end
      end
      if (mode_left == 0) begin
        ready_mode = ready_mode_e'($urandom_range(0, 3));
        mode_left  = $urandom_range(16, 96);
      end else begin
        mode_left--;
      end
      case (ready_mode)
        ReadyAlways:  out_ready_i <= 1'b1;
        ReadyCoin:    out_ready_i <= 1'($urandom_range(0, 1));
        ReadyPattern: out_ready_i <= (cycle_count % 5) < 3;
        default:      out_ready_i <= ($urandom_range(0, 7) == 0);
      endcase
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) quiet_cycles = 0;
      else quiet_cycles++;
      if (quiet_cycles >= QuietLimit) begin
        $display("CHECK FAILED");
        $finish;
      end
    end
  end

  initial begin : stimulus
    int unsigned n_items;
    logic [gks_pkg::KeyW-1:0] key;
    key_shadow = gks_pkg::KeyReset;
    reload_seeds();
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;

    // reset key leaves short and mid at zero: keystream is all zero
    push_item(8'h00, 1'b0);
    push_item(8'hFF, 1'b0);
    push_item(8'h55, 1'b1);
    push_item(8'hAA, 1'b0);
    wait_drained();
    // new key only applies at the next restart; zero key locks up
    write_key(32'h0000_0000);
    push_item(8'hFF, 1'b0);
    push_item(8'hFF, 1'b1);
    push_item(8'h00, 1'b0);
    push_item(8'hA5, 1'b0);
    wait_drained();
    write_key(32'hFFFF_FFFF);
    push_item(8'h00, 1'b0);
    push_item(8'hFF, 1'b1);
    push_item(8'h00, 1'b0);
    push_item(8'h3C, 1'b0);
    push_item(8'hC3, 1'b1);
    wait_drained();
    // bits 16 and 24 are not part of any seed
    write_key(32'h0101_0000);
    push_item(8'hFF, 1'b1);
    push_item(8'h0F, 1'b0);
    wait_drained();
    write_key(32'hFE00_0000);
    push_item(8'h81, 1'b1);
    push_item(8'h7E, 1'b0);
    wait_drained();
    write_key(32'h00FE_FFFF);
    push_item(8'h18, 1'b1);
    push_item(8'hE7, 1'b0);
    wait_drained();

    for (int phase = 0; phase < 10; phase++) begin
      case ($urandom_range(0, 7))
        0: key = 32'h0000_0000;
        1: key = 32'hFFFF_FFFF;
        2: key = $urandom() & 32'hFF00_FFFF;
        3: key = $urandom() & 32'h00FF_FFFF;
        default: key = $urandom();
      endcase
      write_key(key);
      n_items = $urandom_range(100, 160);
      push_item(8'($urandom_range(0, 255)), $urandom_range(0, 7) != 0);
      for (int i = 1; i < n_items; i++) begin
        push_item(8'($urandom_range(0, 255)), $urandom_range(0, 19) == 0);
      end
      wait_drained();
    end

    repeat (8) @(posedge clk_i);
    if (errors == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
+incdir+design
design/gks_pkg.sv
design/gks_keygen.sv
design/geffe_keystream_byte_xor.sv
design/gks_checker.sv
test/testbench.sv
